// ===== rtl/lil_pkg.sv =====
// lil_pkg: shared types and codes for the literal and identifier lexer
// no dependencies; used by lil_step and the top level
package lil_pkg;

  localparam int MaxRes = 4;

  // token kinds
  localparam logic [3:0] K_EOF    = 4'd0;
  localparam logic [3:0] K_ERROR  = 4'd1;
  localparam logic [3:0] K_LPAREN = 4'd2;
  localparam logic [3:0] K_COMMA  = 4'd3;
  localparam logic [3:0] K_RPAREN = 4'd4;
  localparam logic [3:0] K_IDENT  = 4'd5;
  localparam logic [3:0] K_STRING = 4'd6;
  localparam logic [3:0] K_U32    = 4'd7;
  localparam logic [3:0] K_U64    = 4'd8;
  localparam logic [3:0] K_F64    = 4'd9;
  localparam logic [3:0] K_F32    = 4'd10;

  // lexer modes
  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_IDENT  = 4'd1;
  localparam logic [3:0] M_STR    = 4'd2;
  localparam logic [3:0] M_ESC    = 4'd3;
  localparam logic [3:0] M_SIGN   = 4'd4;
  localparam logic [3:0] M_ZERO   = 4'd5;
  localparam logic [3:0] M_PREFIX = 4'd6;
  localparam logic [3:0] M_INT    = 4'd7;
  localparam logic [3:0] M_FLOAT  = 4'd8;
  localparam logic [3:0] M_EXPS   = 4'd9;
  localparam logic [3:0] M_ERROR  = 4'd10;

  localparam logic [63:0] HIGH_HALF = 64'hFFFF_FFFF_0000_0000;

  typedef struct packed {
    logic [3:0]  mode;
    logic [4:0]  base;
    logic [63:0] acc;
    logic        neg;
    logic [7:0]  held_char;
    logic        held_valid;
    logic        str_empty;
  } lex_state_t;

  localparam lex_state_t STATE_RESET = '{M_IDLE, 5'd10, 64'd0, 1'b0, 8'd0, 1'b0, 1'b1};

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic [7:0]  text_char;
    logic        char_valid;
    logic        token_done;
    logic        last_result;
  } lex_res_t;

endpackage

// ===== rtl/lil_in_if.sv =====
// lil_in_if: byte channel into the lexer
// depends on nothing
interface lil_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] input_byte;
  logic       end_of_buffer;
  modport source (output valid, input ready, output input_byte, output end_of_buffer);
  modport sink (input valid, output ready, input input_byte, input end_of_buffer);
endinterface

// ===== rtl/lil_out_if.sv =====
// lil_out_if: token result channel out of the lexer
// depends on nothing
interface lil_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [63:0] token_value;
  logic [7:0]  text_char;
  logic        char_valid;
  logic        token_done;
  logic        last_result;
  modport source (output valid, input ready, output token_kind, output token_value,
                  output text_char, output char_valid, output token_done, output last_result);
  modport sink (input valid, output ready, input token_kind, input token_value,
                input text_char, input char_valid, input token_done, input last_result);
endinterface

// ===== rtl/literal_and_identifier_lexer.sv =====
// literal_and_identifier_lexer: streaming tokenizer top level
// depends on lil_pkg, lil_in_if, lil_out_if and lil_step
//
// One source byte is accepted per cycle while the result register is empty or
// its last result is being taken. The lexer state and all results of a byte are
// computed in lil_step and captured in a four-entry result register at accept;
// results then leave one per cycle while out_ch is ready. A byte that gives no
// result frees the input in the next cycle; else the result register drains first.
module literal_and_identifier_lexer (
  input  logic        clk,
  input  logic        rst_n,
  lil_in_if.sink      in_ch,
  lil_out_if.source   out_ch
);
  import lil_pkg::*;

  lex_state_t              state_r;
  lex_state_t              state_nxt;
  lex_res_t [MaxRes-1:0]   buf_r;
  lex_res_t [MaxRes-1:0]   res_nxt;
  logic [2:0]              res_cnt;
  logic [2:0]              rem_r;
  logic [1:0]              idx_r;
  logic                    take;
  logic                    acc_in;

  lil_step u_step (
    .cur     (state_r),
    .in_byte (in_ch.input_byte),
    .in_eob  (in_ch.end_of_buffer),
    .nxt     (state_nxt),
    .res     (res_nxt),
    .res_cnt (res_cnt)
  );

  // handshakes
  assign take        = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (rem_r == 3'd0) || (rem_r == 3'd1 && take);
  assign acc_in      = in_ch.valid && in_ch.ready;

  // lexer state and result counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
      rem_r   <= 3'd0;
      idx_r   <= 2'd0;
    end else if (acc_in) begin
      state_r <= state_nxt;
      rem_r   <= res_cnt;
      idx_r   <= 2'd0;
    end else if (take) begin
      rem_r <= rem_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc_in) buf_r <= res_nxt;
  end

  assign out_ch.valid       = rem_r != 3'd0;
  assign out_ch.token_kind  = buf_r[idx_r].token_kind;
  assign out_ch.token_value = buf_r[idx_r].token_value;
  assign out_ch.text_char   = buf_r[idx_r].text_char;
  assign out_ch.char_valid  = buf_r[idx_r].char_valid;
  assign out_ch.token_done  = buf_r[idx_r].token_done;
  assign out_ch.last_result = buf_r[idx_r].last_result;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'(MaxRes)) else $error("result count overflow");
  a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_result |-> rem_r == 3'd1) else $error("last flag misplaced");
  a_eob_resets: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && in_ch.end_of_buffer |=> state_r.mode == M_IDLE && !state_r.held_valid)
    else $error("state not cleared after end of buffer");
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.token_kind == K_EOF |-> out_ch.last_result)
    else $error("eof not last");
`endif

endmodule

// ===== rtl/lil_step.sv =====
// lil_step: next-state and result logic for one source byte
// depends on lil_pkg
module lil_step (
  input  lil_pkg::lex_state_t             cur,
  input  logic [7:0]                      in_byte,
  input  logic                            in_eob,
  output lil_pkg::lex_state_t             nxt,
  output lil_pkg::lex_res_t [lil_pkg::MaxRes-1:0] res,
  output logic [2:0]                      res_cnt
);
  import lil_pkg::*;

  typedef struct packed {
    lex_state_t             s;
    lex_res_t [MaxRes-1:0]  r;
    logic [2:0]             n;
  } ctx_t;

  function automatic logic [7:0] digit_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'd255;
    if (c >= "0" && c <= "9") d = c - 8'd48;
    else if (c >= "a" && c <= "z") d = c - 8'd87;
    else if (c >= "A" && c <= "Z") d = c - 8'd55;
    return d;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic ctx_t f_emit(ctx_t x, logic [3:0] k, logic [63:0] v, logic [7:0] ch,
                                  logic cv, logic dn);
    if (x.n < 3'(MaxRes)) begin
      x.r[x.n[1:0]] = '{k, v, ch, cv, dn, 1'b0};
      x.n = x.n + 3'd1;
    end
    return x;
  endfunction

  function automatic ctx_t f_error(ctx_t x);
    x = f_emit(x, K_ERROR, 64'd0, 8'd0, 1'b0, 1'b1);
    x.s.held_valid = 1'b0;
    x.s.mode = M_ERROR;
    return x;
  endfunction

  function automatic ctx_t f_emit_int(ctx_t x);
    logic [63:0] v;
    logic [63:0] hi;
    v = x.s.neg ? (~x.s.acc + 64'd1) : x.s.acc;
    hi = v & HIGH_HALF;
    return f_emit(x, (hi == 64'd0 || hi == HIGH_HALF) ? K_U32 : K_U64, v, 8'd0, 1'b0, 1'b1);
  endfunction

  function automatic ctx_t f_push_str(ctx_t x, logic [7:0] c);
    if (x.s.held_valid) x = f_emit(x, K_STRING, 64'd0, x.s.held_char, 1'b1, 1'b0);
    x.s.held_char = c;
    x.s.held_valid = 1'b1;
    x.s.str_empty = 1'b0;
    return x;
  endfunction

  function automatic ctx_t f_start_number(ctx_t x, logic [7:0] c);
    x.s.base = 5'd10;
    x.s.acc = 64'd0;
    if (c == "0") x.s.mode = M_ZERO;
    else begin
      x.s.acc = {56'd0, c - 8'd48};
      x.s.mode = M_INT;
    end
    return x;
  endfunction

  function automatic ctx_t f_start_token(ctx_t x, logic [7:0] c);
    x.s.mode = M_IDLE;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
    end else if (is_digit(c)) begin
      x.s.neg = 1'b0;
      x = f_start_number(x, c);
    end else if (c == "-" || c == "+") begin
      x.s.neg = (c == "-");
      x.s.mode = M_SIGN;
    end else if (c == "(") begin
      x = f_emit(x, K_LPAREN, 64'd0, 8'd0, 1'b0, 1'b1);
    end else if (c == ",") begin
      x = f_emit(x, K_COMMA, 64'd0, 8'd0, 1'b0, 1'b1);
    end else if (c == ")") begin
      x = f_emit(x, K_RPAREN, 64'd0, 8'd0, 1'b0, 1'b1);
    end else if (c == "\"") begin
      x.s.held_valid = 1'b0;
      x.s.str_empty = 1'b1;
      x.s.mode = M_STR;
    end else if (is_letter(c)) begin
      x.s.held_char = c;
      x.s.held_valid = 1'b1;
      x.s.mode = M_IDENT;
    end else begin
      x = f_error(x);
    end
    return x;
  endfunction

  function automatic ctx_t f_step_ident(ctx_t x, logic [7:0] c);
    if (is_letter(c) || is_digit(c)) begin
      x = f_emit(x, K_IDENT, 64'd0, x.s.held_char, 1'b1, 1'b0);
      x.s.held_char = c;
    end else begin
      x = f_emit(x, K_IDENT, 64'd0, x.s.held_char, 1'b1, 1'b1);
      x.s.held_valid = 1'b0;
      x = f_start_token(x, c);
    end
    return x;
  endfunction

  // shift-add multiply by the current base
  function automatic logic [63:0] mul_base(logic [63:0] a, logic [4:0] b);
    logic [63:0] m;
    case (b)
      5'd2:    m = a << 1;
      5'd8:    m = a << 3;
      5'd16:   m = a << 4;
      default: m = (a << 3) + (a << 1);
    endcase
    return m;
  endfunction

  function automatic ctx_t f_step_int(ctx_t x, logic [7:0] c);
    logic [7:0] d;
    d = digit_val(c);
    if (d < {3'd0, x.s.base}) begin
      x.s.acc = mul_base(x.s.acc, x.s.base) + {56'd0, d};
    end else if (c == ".") begin
      x.s.mode = M_FLOAT;
    end else if (c == "e" || c == "E") begin
      x.s.mode = M_EXPS;
    end else if (c == "l" || c == "L") begin
      x = f_emit(x, K_U64, x.s.acc, 8'd0, 1'b0, 1'b1);
      x.s.mode = M_IDLE;
    end else begin
      x = f_emit_int(x);
      x = f_start_token(x, c);
    end
    return x;
  endfunction

  function automatic ctx_t f_step_float(ctx_t x, logic [7:0] c);
    if (digit_val(c) < {3'd0, x.s.base}) begin
    end else if (c == "f" || c == "F") begin
      x = f_emit(x, K_F32, 64'd0, 8'd0, 1'b0, 1'b1);
      x.s.mode = M_IDLE;
    end else begin
      x = f_emit(x, K_F64, 64'd0, 8'd0, 1'b0, 1'b1);
      x = f_start_token(x, c);
    end
    return x;
  endfunction

  function automatic ctx_t f_prefix_fallback(ctx_t x);
    x.s.acc = 64'd0;
    x = f_emit_int(x);
    x.s.mode = M_IDENT;
    x.s.held_valid = 1'b1;
    return x;
  endfunction

  ctx_t c0, c1, c2;
  logic [7:0] dv;

  // per-mode byte handling
  always_comb begin
    c0 = '0;
    c0.s = cur;
    dv = digit_val(in_byte);
    c1 = c0;
    case (cur.mode)
      M_IDENT: c1 = f_step_ident(c0, in_byte);
      M_STR: begin
        if (in_byte == "\"") begin
          if (cur.str_empty) c1 = f_emit(c0, K_STRING, 64'd0, 8'd0, 1'b0, 1'b1);
          else c1 = f_emit(c0, K_STRING, 64'd0, cur.held_char, 1'b1, 1'b1);
          c1.s.held_valid = 1'b0;
          c1.s.mode = M_IDLE;
        end else if (in_byte == "\\") begin
          c1.s.mode = M_ESC;
        end else begin
          c1 = f_push_str(c0, in_byte);
        end
      end
      M_ESC: begin
        c0.s.mode = M_STR;
        if (in_byte == "n") c1 = f_push_str(c0, 8'd10);
        else if (in_byte == "r") c1 = f_push_str(c0, 8'd13);
        else if (in_byte == "t") c1 = f_push_str(c0, 8'd9);
        else if (in_byte == "f") c1 = f_push_str(c0, 8'd12);
        else c1 = f_error(c0);
      end
      M_SIGN: begin
        if (is_digit(in_byte)) c1 = f_start_number(c0, in_byte);
        else c1 = f_error(c0);
      end
      M_ZERO: begin
        if (in_byte >= "0" && in_byte <= "7") begin
          c1.s.base = 5'd8;
          c1.s.acc = {56'd0, in_byte - 8'd48};
          c1.s.mode = M_INT;
        end else if (in_byte == "x" || in_byte == "X" || in_byte == "b" ||
                     in_byte == "B" || in_byte == "o" || in_byte == "O") begin
          c1.s.base = (in_byte == "x" || in_byte == "X") ? 5'd16 :
                      (in_byte == "b" || in_byte == "B") ? 5'd2 : 5'd8;
          c1.s.held_char = in_byte;
          c1.s.held_valid = 1'b0;
          c1.s.mode = M_PREFIX;
        end else begin
          c0.s.mode = M_INT;
          c1 = f_step_int(c0, in_byte);
        end
      end
      M_PREFIX: begin
        if (dv < {3'd0, cur.base}) begin
          c1.s.acc = {56'd0, dv};
          c1.s.mode = M_INT;
        end else begin
          c1 = f_step_ident(f_prefix_fallback(c0), in_byte);
        end
      end
      M_INT: c1 = f_step_int(c0, in_byte);
      M_EXPS: begin
        if (in_byte == "-" || in_byte == "+") c1.s.mode = M_FLOAT;
        else c1 = f_step_float(c0, in_byte);
      end
      M_FLOAT: c1 = f_step_float(c0, in_byte);
      M_ERROR: c1 = c0;
      default: c1 = f_start_token(c0, in_byte);
    endcase

    // end of buffer: flush the pending token, then eof and back to reset
    c2 = c1;
    if (in_eob) begin
      case (c1.s.mode)
        M_IDENT: c2 = f_emit(c1, K_IDENT, 64'd0, c1.s.held_char, 1'b1, 1'b1);
        M_STR, M_ESC, M_SIGN: c2 = f_emit(c1, K_ERROR, 64'd0, 8'd0, 1'b0, 1'b1);
        M_ZERO: begin
          c2.s.acc = 64'd0;
          c2 = f_emit_int(c2);
        end
        M_PREFIX: begin
          c2 = f_prefix_fallback(c1);
          c2 = f_emit(c2, K_IDENT, 64'd0, c2.s.held_char, 1'b1, 1'b1);
        end
        M_INT: c2 = f_emit_int(c1);
        M_FLOAT, M_EXPS: c2 = f_emit(c1, K_F64, 64'd0, 8'd0, 1'b0, 1'b1);
        default: c2 = c1;
      endcase
      c2 = f_emit(c2, K_EOF, 64'd0, 8'd0, 1'b0, 1'b1);
      c2.s = STATE_RESET;
    end

    // mark the final result of this byte
    for (int i = 0; i < MaxRes; i++) begin
      if (c2.n != 3'd0 && 3'(i) == c2.n - 3'd1) c2.r[i].last_result = 1'b1;
    end
  end

  assign nxt = c2.s;
  assign res = c2.r;
  assign res_cnt = c2.n;

endmodule
